### rtl/cdte_pkg.sv
package cdte_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    // Register indexes on the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BASE_YEAR  = 2'd0,
        REG_UNIX_MODE  = 2'd1,
        REG_BCD_INPUTS = 2'd2
    } cfg_reg_t;

    // Register reset values
    localparam logic [11:0] BASE_YEAR_RESET = 12'd2000;
    localparam logic        UNIX_MODE_RESET = 1'b1;
    localparam logic        BCD_MODE_RESET  = 1'b1;

    // Time constants
    localparam logic [11:0] UNIX_BASE_YEAR = 12'd2000;
    localparam logic [31:0] UNIX_OFFSET    = 32'd946684800;
    localparam logic [31:0] SECS_PER_YEAR  = 32'd31536000;
    localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
    localparam logic [19:0] SECS_PER_HOUR  = 20'd3600;
    localparam logic [19:0] SECS_PER_MIN   = 20'd60;
    localparam logic [3:0]  MONTH_MIN      = 4'd1;
    localparam logic [3:0]  MONTH_MAX      = 4'd12;
    localparam logic [3:0]  MONTH_FEB      = 4'd2;
    localparam logic [7:0]  DAY_MAX        = 8'd31;
    localparam logic [7:0]  HOUR_BCD_MASK  = 8'h3f;
    localparam logic [7:0]  SEC_BCD_MASK   = 8'h7f;

    // Divide by 100 through a reciprocal: exact for arguments below 6400
    localparam logic [12:0] RECIP_100       = 13'd5243;
    localparam int          RECIP_100_SHIFT = 19;

    // Request payloads
    typedef struct packed {
        logic [7:0] year_count;
        logic [7:0] month_value;
        logic [7:0] day_value;
        logic [7:0] hour_value;
        logic [7:0] minute_value;
        logic [7:0] second_value;
    } in_t;

    typedef struct packed {
        logic [31:0] epoch_seconds;
        logic        bad_date;
    } out_t;

    // Decoded fields after the first stage
    typedef struct packed {
        logic [7:0]  years;
        logic [3:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
        logic        bad;
        logic [11:0] base;
        logic        unix;
    } dec_t;

    // Scaled terms after the second stage
    typedef struct packed {
        logic [31:0]        yr_secs;
        logic [19:0]        tod;
        logic signed [10:0] day_idx;
        logic [12:0]        y_end;
        logic [11:0]        base;
        logic               past_feb;
        logic               unix;
        logic               bad;
    } scl_t;

    // High nibble times ten plus low nibble, nibbles unchecked
    function automatic logic [7:0] bcd_decode(input logic [7:0] v);
        logic [7:0] hi;
        hi = {4'd0, v[7:4]};
        return (hi << 3) + (hi << 1) + {4'd0, v[3:0]};
    endfunction

    // Days in the year before the first of a month (month 1..12)
    function automatic logic [8:0] days_before_month(input logic [3:0] month);
        logic [8:0] d;
        unique case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    function automatic logic [5:0] div100(input logic [12:0] x);
        logic [25:0] p;
        p = x * RECIP_100;
        return p[RECIP_100_SHIFT +: 6];
    endfunction

    // Leap years in [0, y) under the Gregorian rule, year 0 counted as leap
    function automatic logic [10:0] leaps_below(input logic [12:0] y);
        logic [12:0] by4;
        logic [12:0] q400_arg;
        by4      = y + 13'd3;
        q400_arg = 13'((y + 13'd399) >> 2);
        return 11'(by4 >> 2) - {5'd0, div100(y + 13'd99)} + {5'd0, div100(q400_arg)};
    endfunction

endpackage

### rtl/cdte_decode.sv
module cdte_decode (
    input  logic           clk,
    input  logic           load,
    input  logic [11:0]    base_year,
    input  logic           unix_mode,
    input  logic           bcd_inputs,
    input  cdte_pkg::in_t  in_data,
    output cdte_pkg::dec_t dec
);
    import cdte_pkg::*;

    logic [7:0] years;
    logic [7:0] month_raw;
    logic [7:0] day;
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
    dec_t       dec_next;
    dec_t       dec_reg;

    // In BCD mode decode the bytes, masking the hour and second control bits; else pass them through
    always_comb
    begin
        if (bcd_inputs)
        begin
            years     = bcd_decode(in_data.year_count);
            month_raw = bcd_decode(in_data.month_value);
            day       = bcd_decode(in_data.day_value);
            hour      = bcd_decode(in_data.hour_value & HOUR_BCD_MASK);
            minute    = bcd_decode(in_data.minute_value);
            second    = bcd_decode(in_data.second_value & SEC_BCD_MASK);
        end
        else
        begin
            years     = in_data.year_count;
            month_raw = in_data.month_value;
            day       = in_data.day_value;
            hour      = in_data.hour_value;
            minute    = in_data.minute_value;
            second    = in_data.second_value;
        end
    end

    // Clamp month, flag illegal month or day, pick the base year
    always_comb
    begin
        dec_next.years  = years;
        dec_next.day    = day;
        dec_next.hour   = hour;
        dec_next.minute = minute;
        dec_next.second = second;
        dec_next.unix   = unix_mode;
        dec_next.base   = unix_mode ? UNIX_BASE_YEAR : base_year;
        dec_next.bad    = (day == 8'd0) || (day > DAY_MAX);
        if (month_raw == 8'd0)
        begin
            dec_next.month = MONTH_MIN;
            dec_next.bad   = 1'b1;
        end
        else if (month_raw > {4'd0, MONTH_MAX})
        begin
            dec_next.month = MONTH_MAX;
            dec_next.bad   = 1'b1;
        end
        else
        begin
            dec_next.month = month_raw[3:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dec_reg <= dec_next;
        end
    end

    assign dec = dec_reg;

endmodule

### rtl/cdte_scale.sv
module cdte_scale (
    input  logic           clk,
    input  logic           load,
    input  cdte_pkg::dec_t dec,
    output cdte_pkg::scl_t scl
);
    import cdte_pkg::*;

    scl_t scl_next;
    scl_t scl_reg;

    // Scale whole years and time of day, index the day within the year
    always_comb
    begin
        scl_next.yr_secs  = {24'd0, dec.years} * SECS_PER_YEAR;
        scl_next.tod      = {12'd0, dec.hour} * SECS_PER_HOUR
                          + {12'd0, dec.minute} * SECS_PER_MIN
                          + {12'd0, dec.second};
        scl_next.day_idx  = $signed({2'b00, days_before_month(dec.month)})
                          + $signed({3'b000, dec.day}) - 11'sd1;
        scl_next.y_end    = {1'b0, dec.base} + {5'd0, dec.years};
        scl_next.base     = dec.base;
        scl_next.past_feb = dec.month > MONTH_FEB;
        scl_next.unix     = dec.unix;
        scl_next.bad      = dec.bad;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            scl_reg <= scl_next;
        end
    end

    assign scl = scl_reg;

endmodule

### rtl/cdte_leap.sv
module cdte_leap (
    input  logic        clk,
    input  logic        load_count,
    input  logic        load_sum,
    input  logic [11:0] base,
    input  logic [12:0] y_end,
    input  logic        past_feb,
    output logic [6:0]  extra_days
);
    import cdte_pkg::*;

    logic [10:0] lb_reg;
    logic [10:0] le_reg;
    logic [10:0] le1_reg;
    logic        past_feb_reg;
    logic [10:0] leaps;
    logic [10:0] end_leap;
    logic [6:0]  extra_next;
    logic [6:0]  extra_reg;

    // Count leap years below the base, the end year and the year after
    always_ff @(posedge clk)
    begin
        if (load_count)
        begin
            lb_reg       <= leaps_below({1'b0, base});
            le_reg       <= leaps_below(y_end);
            le1_reg      <= leaps_below(y_end + 13'd1);
            past_feb_reg <= past_feb;
        end
    end

    // Count leap days from the base year to the end year, adding the end year's leap day once February is past
    always_comb
    begin
        leaps      = le_reg - lb_reg;
        end_leap   = le1_reg - le_reg;
        extra_next = leaps[6:0] + {6'd0, past_feb_reg & end_leap[0]};
    end

    always_ff @(posedge clk)
    begin
        if (load_sum)
        begin
            extra_reg <= extra_next;
        end
    end

    assign extra_days = extra_reg;

endmodule

### rtl/calendar_date_to_epoch_seconds.sv
// Calendar date to epoch seconds converter.
//
// Requests arrive on in_valid/in_ready with one clock date and time in
// in_data; results leave on out_valid/out_ready as out_data, one result for
// each request, in order. Configuration (base year, unix mode, BCD inputs)
// is to be written via cfg_write/cfg_index/cfg_data while no request is in
// flight (unenforced by the block); an index with no register is ignored.
//
// A request passes through five register stages (decode, scale, leap count,
// leap difference, final sum), each of which passes one request per cycle
// while out_ready is high, so throughput is one request per cycle unless the
// receiver holds out_ready low.
//
// Reset empties the pipeline and sets base year 2000, unix mode and BCD
// inputs. When the receiver holds out_ready low, the stages fill up behind
// the output register and in_ready falls only once every stage holds a
// request; nothing is dropped or repeated.
module calendar_date_to_epoch_seconds (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  cdte_pkg::in_t                in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output cdte_pkg::out_t               out_data,
    input  logic                         cfg_write,
    input  logic [cdte_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cdte_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cdte_pkg::*;

    localparam int STAGES = 5;

    logic [11:0]       base_year_reg;
    logic              unix_mode_reg;
    logic              bcd_inputs_reg;
    logic [STAGES:1]   valid_reg;
    logic [STAGES+1:1] load;
    dec_t              dec;
    scl_t              scl;
    logic [6:0]        extra_days;
    logic [31:0]       sum_a_reg;
    logic [31:0]       day_secs_reg;
    logic              bad3_reg;
    logic [31:0]       sum_b_reg;
    logic              bad4_reg;
    out_t              out_next;
    out_t              out_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_year_reg  <= BASE_YEAR_RESET;
            unix_mode_reg  <= UNIX_MODE_RESET;
            bcd_inputs_reg <= BCD_MODE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BASE_YEAR:  base_year_reg  <= cfg_data[11:0];
                REG_UNIX_MODE:  unix_mode_reg  <= cfg_data[0];
                REG_BCD_INPUTS: bcd_inputs_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // A stage loads when it is empty or its content moves on
    always_comb
    begin
        load[STAGES+1] = out_ready;
        for (int k = STAGES; k >= 1; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign in_ready = load[1];

    // Advance valid bits with their requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[1])
            begin
                valid_reg[1] <= in_valid;
            end
            for (int k = 2; k <= STAGES; k++)
            begin
                if (load[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Stage 1: decode
    cdte_decode u_decode (
        .clk        (clk),
        .load       (load[1]),
        .base_year  (base_year_reg),
        .unix_mode  (unix_mode_reg),
        .bcd_inputs (bcd_inputs_reg),
        .in_data    (in_data),
        .dec        (dec)
    );

    // Stage 2: scale
    cdte_scale u_scale (
        .clk  (clk),
        .load (load[2]),
        .dec  (dec),
        .scl  (scl)
    );

    // Stages 3 and 4: leap days
    cdte_leap u_leap (
        .clk        (clk),
        .load_count (load[3]),
        .load_sum   (load[4]),
        .base       (scl.base),
        .y_end      (scl.y_end),
        .past_feb   (scl.past_feb),
        .extra_days (extra_days)
    );

    // Stage 3: add year, time of day and offset; scale the day index
    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            sum_a_reg    <= scl.yr_secs + {12'd0, scl.tod}
                          + (scl.unix ? UNIX_OFFSET : 32'd0);
            day_secs_reg <= {{21{scl.day_idx[10]}}, scl.day_idx} * SECS_PER_DAY;
            bad3_reg     <= scl.bad;
        end
    end

    // Stage 4: add the day offset
    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            sum_b_reg <= sum_a_reg + day_secs_reg;
            bad4_reg  <= bad3_reg;
        end
    end

    // Stage 5: add the leap days
    always_comb
    begin
        out_next.epoch_seconds = sum_b_reg + {25'd0, extra_days} * SECS_PER_DAY;
        out_next.bad_date      = bad4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = valid_reg[STAGES];
    assign out_data  = out_reg;

endmodule
